>>> rtl/fgn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgn_pkg
// Shared types, constants and the gradient selection for the fractal noise core.
// ----------------------------------------------------------------------------
package fgn_pkg;

   localparam int TABLE_SIZE  = 256;
   localparam int FRAC_BITS   = 16;
   localparam int MAX_OCTAVES = 16;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_NOISE2 = 2'd1;
   localparam logic [1:0] CMD_NOISE3 = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic CSR_OCTAVE_COUNT = 1'b0;
   localparam logic CSR_PERSISTENCE  = 1'b1;

   localparam logic [16:0] WEIGHT_ONE = 17'h10000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_FADE,
      ST_MIX,
      ST_ACC,
      ST_DIV,
      ST_DONE
   } state_type;

   // Dot product of the corner distance with the gradient picked by the hash.
   function automatic logic signed [18:0] grad_dot(input logic [3:0] h, input logic is3d,
                                                   input logic signed [18:0] x,
                                                   input logic signed [18:0] y,
                                                   input logic signed [18:0] z);
      logic signed [18:0] p;
      logic signed [18:0] q;
      logic signed [18:0] r;
      p = 19'sd0;
      q = 19'sd0;
      if (!is3d) begin
         case (h[2:0])
            3'd0: r = x + y;
            3'd1: r = y - x;
            3'd2: r = x - y;
            3'd3: r = -x - y;
            3'd4: r = y;
            3'd5: r = x;
            3'd6: r = -y;
            default: r = -x;
         endcase
      end else begin
         p = (h < 4'd8) ? x : y;
         q = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
         r = (h[0] ? -p : p) + (h[1] ? -q : q);
      end
      return r;
   endfunction

endpackage

>>> rtl/fgn_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgn_req_if
// Request channel: table loads and 2D or 3D noise samples.
// ----------------------------------------------------------------------------
interface fgn_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic signed [31:0] coord_x;
   logic signed [31:0] coord_y;
   logic signed [31:0] coord_z;
   logic [7:0]         entry_index;
   logic [7:0]         entry_value;

   modport source (output valid, cmd, coord_x, coord_y, coord_z, entry_index, entry_value,
                   input ready);
   modport sink (input valid, cmd, coord_x, coord_y, coord_z, entry_index, entry_value,
                 output ready);
endinterface

>>> rtl/fgn_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgn_rsp_if
// Response channel: one normalized noise value per noise request.
// ----------------------------------------------------------------------------
interface fgn_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] noise_value;

   modport source (output valid, noise_value, input ready);
   modport sink (input valid, noise_value, output ready);
endinterface

>>> rtl/fgn_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fgn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> rtl/fractal_gradient_noise_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractal_gradient_noise_core
// Multi-octave 2D/3D gradient noise with one shared multiplier and a sequencer.
// ----------------------------------------------------------------------------
// Timing: a load writes the table when it transfers. Each octave of a 2D or 3D item
// is paced by the single table read port and the single 19x18 multiplier; a
// bit-serial division and the emit step follow the last octave.
// One item is in work at a time; the response register lets the next request
// transfer while a result waits. Synchronous reset clears control and config;
// the permutation table is not cleared and must be loaded before use.
module fractal_gradient_noise_core (
   input  logic                 clock,
   input  logic                 reset,
   fgn_req_if.sink              req_chan,
   fgn_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [16:0]          csr_wdata
);
   import fgn_pkg::*;

   state_type state_ff, state_in;
   logic [4:0]  oct_cfg_ff;
   logic [16:0] pers_cfg_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;

   logic        is3d_ff, is3d_in;
   logic [23:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [4:0]  oct_ff, oct_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [1:0]  ph_ff, ph_in;
   logic [1:0]  lvl_ff, lvl_in;
   logic [5:0]  div_cnt_ff, div_cnt_in;

   logic [7:0]  ha_ff, ha_in, hb_ff, hb_in;
   logic [7:0]  q_ff [0:3];
   logic [7:0]  q_in [0:3];
   logic [7:0]  hv_ff [0:7];
   logic [7:0]  hv_in [0:7];
   logic signed [18:0] val_ff [0:3];
   logic signed [18:0] val_in [0:3];

   logic [15:0] pw_ff, pw_in, t3_ff, t3_in, t4_ff, t4_in, t5_ff, t5_in;
   logic [16:0] fu_ff, fu_in, fv_ff, fv_in, fw_ff, fw_in;

   logic signed [36:0] prod_ff, acc_ff, acc_in;
   logic signed [39:0] total_ff, total_in;
   logic [20:0] wsum_ff, wsum_in;
   logic [16:0] w_ff, w_in;
   logic [21:0] rem_ff, rem_in;
   logic [39:0] quo_ff, quo_in;
   logic        neg_ff, neg_in;

   logic signed [18:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [36:0] mul_prod;

   logic        ram_we;
   logic [7:0]  rd_addr, ram_rdata;
   logic        rd_last, pair_last, mix_top, oct_last;
   logic [4:0]  n_eff;
   logic [16:0] pers_eff;
   logic [15:0] frac_t;
   logic signed [21:0] fade_raw;
   logic [16:0] fade_q, mix_f;
   logic [2:0]  mix_idx;
   logic signed [18:0] mix_op, dx, dy, dz;
   logic signed [36:0] mix_sum;
   logic [22:0] trial;
   logic [39:0] total_mag;
   logic        req_xfer, rsp_free;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.noise_value = rsp_data_ff;
   assign ram_we = req_xfer && (req_chan.cmd == CMD_LOAD);

   fgn_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_perm (
      .clock (clock),
      .we    (ram_we),
      .waddr (req_chan.entry_index),
      .wdata (req_chan.entry_value),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   assign n_eff = (oct_cfg_ff == 5'd0) ? 5'd1 :
                  ((oct_cfg_ff > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES) : oct_cfg_ff);
   assign pers_eff = (pers_cfg_ff > WEIGHT_ONE) ? WEIGHT_ONE : pers_cfg_ff;
   assign oct_last = (oct_ff == n_eff - 5'd1);
   assign mul_prod = mul_a * mul_b;

   // Table address for the current read; the hash chain has two levels in 2D
   // and three in 3D.
   always_comb begin
      case (lvl_ff)
         2'd0: rd_addr = cx_ff[23:16] + {7'd0, cnt_ff[0]};
         2'd1: begin
            if (is3d_ff) begin
               rd_addr = (cnt_ff[1] ? hb_ff : ha_ff) + cy_ff[23:16] + {7'd0, cnt_ff[0]};
            end else begin
               rd_addr = (cnt_ff[0] ? hb_ff : ha_ff) + cy_ff[23:16] + {7'd0, cnt_ff[1]};
            end
         end
         default: rd_addr = q_ff[{cnt_ff[0], cnt_ff[1]}] + {7'd0, cnt_ff[2]};
      endcase
      case (lvl_ff)
         2'd0: rd_last = (cnt_ff == 3'd1);
         2'd1: rd_last = (cnt_ff == 3'd3);
         default: rd_last = (cnt_ff == 3'd7);
      endcase
   end

   // Quintic fade from the stored powers, clamped to 0..1.
   always_comb begin
      case (lvl_ff)
         2'd0: frac_t = cx_ff[15:0];
         2'd1: frac_t = cy_ff[15:0];
         default: frac_t = cz_ff[15:0];
      endcase
      fade_raw = 22'sd6 * $signed({6'd0, t5_ff}) - 22'sd15 * $signed({6'd0, t4_ff})
               + 22'sd10 * $signed({6'd0, t3_ff});
      if (fade_raw < 22'sd0) begin
         fade_q = 17'd0;
      end else if (fade_raw > $signed({5'd0, WEIGHT_ONE})) begin
         fade_q = WEIGHT_ONE;
      end else begin
         fade_q = fade_raw[16:0];
      end
   end

   // Interpolation operands: corner gradients on the first level, earlier
   // blends afterwards.
   always_comb begin
      mix_idx = {cnt_ff[1:0], (ph_ff == 2'd1)};
      dx = mix_idx[0] ? $signed({3'b111, cx_ff[15:0]}) : $signed({3'b000, cx_ff[15:0]});
      dy = mix_idx[1] ? $signed({3'b111, cy_ff[15:0]}) : $signed({3'b000, cy_ff[15:0]});
      dz = mix_idx[2] ? $signed({3'b111, cz_ff[15:0]}) : $signed({3'b000, cz_ff[15:0]});
      if (lvl_ff == 2'd0) begin
         mix_op = grad_dot(hv_ff[mix_idx][3:0], is3d_ff, dx, dy, dz);
      end else begin
         mix_op = val_ff[mix_idx[1:0]];
      end
      case (lvl_ff)
         2'd0: mix_f = fu_ff;
         2'd1: mix_f = fv_ff;
         default: mix_f = fw_ff;
      endcase
      mix_top = is3d_ff ? (lvl_ff == 2'd2) : (lvl_ff == 2'd1);
      if (is3d_ff) begin
         pair_last = (cnt_ff == (3'd3 >> lvl_ff));
      end else begin
         pair_last = (cnt_ff == (3'd1 >> lvl_ff));
      end
      mix_sum = acc_ff + prod_ff;
      trial = {rem_ff, quo_ff[39]};
      total_mag = total_ff[39] ? 40'(-total_ff) : 40'(total_ff);
   end

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in = rsp_data_ff;
      is3d_in = is3d_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      cz_in = cz_ff;
      oct_in = oct_ff;
      cnt_in = cnt_ff;
      ph_in = ph_ff;
      lvl_in = lvl_ff;
      div_cnt_in = div_cnt_ff;
      ha_in = ha_ff;
      hb_in = hb_ff;
      q_in = q_ff;
      hv_in = hv_ff;
      val_in = val_ff;
      pw_in = pw_ff;
      t3_in = t3_ff;
      t4_in = t4_ff;
      t5_in = t5_ff;
      fu_in = fu_ff;
      fv_in = fv_ff;
      fw_in = fw_ff;
      acc_in = acc_ff;
      total_in = total_ff;
      wsum_in = wsum_ff;
      w_in = w_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      neg_in = neg_ff;
      mul_a = 19'sd0;
      mul_b = 18'sd0;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_chan.cmd == CMD_NOISE2 || req_chan.cmd == CMD_NOISE3)) begin
               is3d_in = (req_chan.cmd == CMD_NOISE3);
               cx_in = req_chan.coord_x[23:0];
               cy_in = req_chan.coord_y[23:0];
               cz_in = req_chan.coord_z[23:0];
               oct_in = 5'd0;
               total_in = 40'sd0;
               wsum_in = 21'd0;
               w_in = WEIGHT_ONE;
               lvl_in = 2'd0;
               cnt_in = 3'd0;
               ph_in = 2'd0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (ph_ff == 2'd0) begin
               ph_in = 2'd1;
            end else begin
               ph_in = 2'd0;
               case (lvl_ff)
                  2'd0: begin
                     if (cnt_ff[0]) begin
                        hb_in = ram_rdata;
                     end else begin
                        ha_in = ram_rdata;
                     end
                  end
                  2'd1: begin
                     if (is3d_ff) begin
                        q_in[cnt_ff[1:0]] = ram_rdata + cz_ff[23:16];
                     end else begin
                        hv_in[cnt_ff] = ram_rdata;
                     end
                  end
                  default: hv_in[cnt_ff] = ram_rdata;
               endcase
               cnt_in = cnt_ff + 3'd1;
               if (rd_last) begin
                  cnt_in = 3'd0;
                  if (lvl_ff == 2'd0 || (lvl_ff == 2'd1 && is3d_ff)) begin
                     lvl_in = lvl_ff + 2'd1;
                  end else begin
                     lvl_in = 2'd0;
                     state_in = ST_FADE;
                  end
               end
            end
         end
         ST_FADE: begin
            // lvl counts the axis here, cnt the power being formed.
            case (ph_ff)
               2'd0: begin
                  mul_a = $signed({3'd0, (cnt_ff == 3'd0) ? frac_t : pw_ff});
                  mul_b = $signed({2'd0, frac_t});
                  ph_in = 2'd1;
               end
               2'd1: begin
                  pw_in = prod_ff[31:16];
                  case (cnt_ff)
                     3'd1: t3_in = prod_ff[31:16];
                     3'd2: t4_in = prod_ff[31:16];
                     3'd3: t5_in = prod_ff[31:16];
                     default: ;
                  endcase
                  if (cnt_ff == 3'd3) begin
                     ph_in = 2'd2;
                  end else begin
                     ph_in = 2'd0;
                     cnt_in = cnt_ff + 3'd1;
                  end
               end
               default: begin
                  case (lvl_ff)
                     2'd0: fu_in = fade_q;
                     2'd1: fv_in = fade_q;
                     default: fw_in = fade_q;
                  endcase
                  ph_in = 2'd0;
                  cnt_in = 3'd0;
                  if ((is3d_ff && lvl_ff == 2'd2) || (!is3d_ff && lvl_ff == 2'd1)) begin
                     lvl_in = 2'd0;
                     state_in = ST_MIX;
                  end else begin
                     lvl_in = lvl_ff + 2'd1;
                  end
               end
            endcase
         end
         ST_MIX: begin
            case (ph_ff)
               2'd0: begin
                  mul_a = mix_op;
                  mul_b = $signed({1'b0, WEIGHT_ONE - mix_f});
                  ph_in = 2'd1;
               end
               2'd1: begin
                  mul_a = mix_op;
                  mul_b = $signed({1'b0, mix_f});
                  acc_in = prod_ff;
                  ph_in = 2'd2;
               end
               default: begin
                  val_in[cnt_ff[1:0]] = mix_sum[34:16];
                  ph_in = 2'd0;
                  if (pair_last) begin
                     cnt_in = 3'd0;
                     if (mix_top) begin
                        lvl_in = 2'd0;
                        state_in = ST_ACC;
                     end else begin
                        lvl_in = lvl_ff + 2'd1;
                     end
                  end else begin
                     cnt_in = cnt_ff + 3'd1;
                  end
               end
            endcase
         end
         ST_ACC: begin
            case (ph_ff)
               2'd0: begin
                  mul_a = val_ff[0];
                  mul_b = $signed({1'b0, w_ff});
                  ph_in = 2'd1;
               end
               2'd1: begin
                  total_in = total_ff + 40'(prod_ff);
                  wsum_in = wsum_ff + {4'd0, w_ff};
                  mul_a = $signed({2'd0, w_ff});
                  mul_b = $signed({1'b0, pers_eff});
                  ph_in = 2'd2;
               end
               default: begin
                  w_in = prod_ff[32:16];
                  ph_in = 2'd0;
                  cx_in = {cx_ff[22:0], 1'b0};
                  cy_in = {cy_ff[22:0], 1'b0};
                  cz_in = {cz_ff[22:0], 1'b0};
                  oct_in = oct_ff + 5'd1;
                  if (oct_last) begin
                     neg_in = total_ff[39];
                     quo_in = total_mag;
                     rem_in = 22'd0;
                     div_cnt_in = 6'd0;
                     state_in = ST_DIV;
                  end else begin
                     state_in = ST_READ;
                  end
               end
            endcase
         end
         ST_DIV: begin
            // Restoring division of |total| by twice the weight sum.
            if (trial >= {1'b0, wsum_ff, 1'b0}) begin
               rem_in = 22'(trial - {1'b0, wsum_ff, 1'b0});
               quo_in = {quo_ff[38:0], 1'b1};
            end else begin
               rem_in = trial[21:0];
               quo_in = {quo_ff[38:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + 6'd1;
            if (div_cnt_ff == 6'd39) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (!neg_ff) begin
                  rsp_data_in = (quo_ff > 40'd32767) ? 16'h7FFF : quo_ff[15:0];
               end else begin
                  rsp_data_in = (quo_ff > 40'd32768) ? 16'h8000 : 16'(~quo_ff[15:0] + 16'd1);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         oct_cfg_ff <= 5'd1;
         pers_cfg_ff <= 17'd32768;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == CSR_OCTAVE_COUNT) begin
            oct_cfg_ff <= csr_wdata[4:0];
         end
         if (csr_we && csr_index == CSR_PERSISTENCE) begin
            pers_cfg_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      is3d_ff <= is3d_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      cz_ff <= cz_in;
      oct_ff <= oct_in;
      cnt_ff <= cnt_in;
      ph_ff <= ph_in;
      lvl_ff <= lvl_in;
      div_cnt_ff <= div_cnt_in;
      ha_ff <= ha_in;
      hb_ff <= hb_in;
      q_ff <= q_in;
      hv_ff <= hv_in;
      val_ff <= val_in;
      pw_ff <= pw_in;
      t3_ff <= t3_in;
      t4_ff <= t4_in;
      t5_ff <= t5_in;
      fu_ff <= fu_in;
      fv_ff <= fv_in;
      fw_ff <= fw_in;
      prod_ff <= mul_prod;
      acc_ff <= acc_in;
      total_ff <= total_in;
      wsum_ff <= wsum_in;
      w_ff <= w_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
   end

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (wsum_ff != 21'd0))
      else $error("division started with a zero weight sum");

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC) |-> (w_ff <= WEIGHT_ONE))
      else $error("octave weight above one");

   a_fade_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX) |-> (mix_f <= WEIGHT_ONE))
      else $error("fade value out of range");

   a_done_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && state_in == ST_IDLE) |=> rsp_valid_ff)
      else $error("finished item produced no response");

endmodule
